FILE: rtl/rtph_pkg.sv
package rtph_pkg;

	localparam int START_W = 19;
	localparam int FIELD_W = 11;
	localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

	localparam logic [3:0] ST_OK            = 4'd0;
	localparam logic [3:0] ST_SHORT         = 4'd1;
	localparam logic [3:0] ST_VERSION       = 4'd2;
	localparam logic [3:0] ST_CSRC_CUT      = 4'd3;
	localparam logic [3:0] ST_EXT_HDR_CUT   = 4'd4;
	localparam logic [3:0] ST_EXT_DATA_CUT  = 4'd5;
	localparam logic [3:0] ST_PAD_NO_PAYLD  = 4'd6;
	localparam logic [3:0] ST_PAD_ZERO      = 4'd7;
	localparam logic [3:0] ST_PAD_TOO_LARGE = 4'd8;

	localparam logic KIND_CSRC    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_packet;
	} in_t;

	typedef struct packed {
		logic               kind;
		logic [3:0]         status;
		logic               marker;
		logic [6:0]         ptype;
		logic [15:0]        seq;
		logic [31:0]        timestamp;
		logic [31:0]        id_word;
		logic               ext_present;
		logic [15:0]        ext_profile;
		logic [15:0]        ext_words;
		logic [FIELD_W-1:0] payload_start;
		logic [FIELD_W-1:0] pay_len;
	} out_t;

	typedef struct packed {
		logic               csrc_vld;
		logic               summ_vld;
		logic               marker;
		logic [6:0]         ptype;
		logic [15:0]        seq;
		logic [31:0]        timestamp;
		logic [31:0]        csrc_word;
		logic [31:0]        ssrc;
		logic               ext_present;
		logic [15:0]        ext_profile;
		logic [15:0]        ext_words;
		logic [3:0]         status;
		logic               pad;
		logic [7:0]         pad_cnt;
		logic [START_W-1:0] len;
		logic [START_W-1:0] pstart;
	} qent_t;

endpackage

FILE: rtl/rtph_front.sv
module rtph_front #(
	parameter int MAX_CSRC = 4,
	parameter int MAX_PACKET_BYTES = 2048
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           byte_valid,
	output logic           byte_ready,
	input  rtph_pkg::in_t  byte_data,
	output logic           push_valid,
	output rtph_pkg::qent_t push_data,
	input  logic           q_full
);

	localparam int PW = $clog2(MAX_PACKET_BYTES);
	localparam int SW = rtph_pkg::START_W;
	localparam logic [PW-1:0] LAST_POS = PW'(MAX_PACKET_BYTES - 1);

	logic [PW-1:0] pos_q, pos_n;
	logic [7:0]    fhb_q, fhb_n, shb_q, shb_n;
	logic [15:0]   seq_q, seq_n, prof_q, prof_n, words_q, words_n;
	logic [31:0]   time_q, time_n, src_q, src_n, word_q, word_n;
	logic [3:0]    csrc_done_q, csrc_done_n;
	logic          seen_q, seen_n;
	logic [SW-1:0] pstart_q, pstart_n;

	logic          accept, last, drop, csrc_emit, xbit;
	logic [7:0]    b;
	logic [SW-1:0] p_w, len_w, csrc_end, csrc_end_n, off_w;
	logic [3:0]    status;

	assign byte_ready = !q_full;
	assign accept = byte_valid && byte_ready;

	always_comb begin
		b = byte_data.data_byte;
		last = byte_data.end_of_packet;
		p_w = SW'(pos_q);
		len_w = p_w + SW'(1);
		csrc_end = SW'({fhb_q[3:0], 2'b00}) + SW'(12);
		xbit = fhb_q[4];
		drop = !last && (pos_q >= LAST_POS);
		csrc_emit = 1'b0;
		off_w = p_w - csrc_end;

		fhb_n = fhb_q;
		shb_n = shb_q;
		seq_n = seq_q;
		time_n = time_q;
		src_n = src_q;
		word_n = word_q;
		csrc_done_n = csrc_done_q;
		prof_n = prof_q;
		words_n = words_q;
		seen_n = seen_q;
		pstart_n = pstart_q;

		if (pos_q == '0) begin
			fhb_n = b;
			shb_n = '0;
			seq_n = '0;
			time_n = '0;
			src_n = '0;
			word_n = '0;
			csrc_done_n = '0;
			prof_n = '0;
			words_n = '0;
			seen_n = 1'b0;
			pstart_n = SW'({b[3:0], 2'b00}) + SW'(12);
		end else if (pos_q == PW'(1)) begin
			shb_n = b;
		end else if (pos_q < PW'(4)) begin
			seq_n = {seq_q[7:0], b};
		end else if (pos_q < PW'(8)) begin
			time_n = {time_q[23:0], b};
		end else if (pos_q < PW'(12)) begin
			src_n = {src_q[23:0], b};
		end else if (p_w < csrc_end) begin
			word_n = {word_q[23:0], b};
			if (pos_q[1:0] == 2'b11) begin
				csrc_emit = (csrc_done_q < 4'(MAX_CSRC));
				if (csrc_done_q != 4'hF) begin
					csrc_done_n = csrc_done_q + 4'd1;
				end
			end
		end else if (xbit && (p_w < csrc_end + SW'(4))) begin
			if (!off_w[1]) begin
				prof_n = {prof_q[7:0], b};
			end else begin
				words_n = {words_q[7:0], b};
			end
			if (off_w[1:0] == 2'b11) begin
				seen_n = 1'b1;
				pstart_n = csrc_end + SW'(4) + SW'({words_q[7:0], b, 2'b00});
			end
		end

		csrc_end_n = SW'({fhb_n[3:0], 2'b00}) + SW'(12);
		if (len_w < SW'(12)) begin
			status = rtph_pkg::ST_SHORT;
		end else if (fhb_n[7:6] != 2'b10) begin
			status = rtph_pkg::ST_VERSION;
		end else if (len_w < csrc_end_n) begin
			status = rtph_pkg::ST_CSRC_CUT;
		end else if (fhb_n[4] && !seen_n) begin
			status = rtph_pkg::ST_EXT_HDR_CUT;
		end else begin
			status = rtph_pkg::ST_OK;
		end

		if (last) begin
			pos_n = '0;
		end else begin
			pos_n = pos_q + PW'(1);
		end

		push_data.csrc_vld = csrc_emit;
		push_data.summ_vld = last;
		push_data.marker = shb_n[7];
		push_data.ptype = shb_n[6:0];
		push_data.seq = seq_n;
		push_data.timestamp = time_n;
		push_data.csrc_word = word_n;
		push_data.ssrc = src_n;
		push_data.ext_present = fhb_n[4];
		push_data.ext_profile = prof_n;
		push_data.ext_words = words_n;
		push_data.status = status;
		push_data.pad = fhb_n[5];
		push_data.pad_cnt = b;
		push_data.len = len_w;
		push_data.pstart = pstart_n;
	end

	assign push_valid = accept && !drop && (csrc_emit || last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			fhb_q <= '0;
			shb_q <= '0;
			seq_q <= '0;
			time_q <= '0;
			src_q <= '0;
			word_q <= '0;
			csrc_done_q <= '0;
			prof_q <= '0;
			words_q <= '0;
			seen_q <= 1'b0;
			pstart_q <= '0;
		end else if (accept && !drop) begin
			pos_q <= pos_n;
			fhb_q <= fhb_n;
			shb_q <= shb_n;
			seq_q <= seq_n;
			time_q <= time_n;
			src_q <= src_n;
			word_q <= word_n;
			csrc_done_q <= csrc_done_n;
			prof_q <= prof_n;
			words_q <= words_n;
			seen_q <= seen_n;
			pstart_q <= pstart_n;
		end
	end

endmodule

FILE: rtl/rtph_queue.sv
module rtph_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  rtph_pkg::qent_t push_data,
	output logic            full,
	output logic            pop_valid,
	output rtph_pkg::qent_t pop_data,
	input  logic            pop
);

	localparam int AW = $clog2(DEPTH);

	rtph_pkg::qent_t mem [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [AW:0]     count_q;
	logic            do_push, do_pop;

	assign full = (count_q == (AW + 1)'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = mem[rd_ptr_q];
	assign do_push = push_valid && !full;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (AW + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (AW + 1)'(1);
			end
		end
	end

endmodule

FILE: rtl/rtph_back.sv
module rtph_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  rtph_pkg::qent_t q_data,
	output logic            q_pop,
	output logic            result_valid,
	input  logic            result_ready,
	output rtph_pkg::out_t  result_data
);

	localparam int SW = rtph_pkg::START_W;
	localparam int FW = rtph_pkg::FIELD_W;

	typedef struct packed {
		rtph_pkg::out_t res;
		logic           pad_chk;
		logic [7:0]     pad_cnt;
		logic [SW-1:0]  plen;
	} stg_t;

	stg_t           stg_s1, stg_n;
	logic           vld_s1;
	rtph_pkg::out_t res_s2, res_n;
	logic           vld_s2;
	logic           half_q;

	logic           mv_s2, ld_s1, issue_csrc;
	logic [SW:0]    diff;
	logic [SW-1:0]  plen_f;

	assign mv_s2 = vld_s1 && (!vld_s2 || result_ready);
	assign ld_s1 = q_valid && (!vld_s1 || mv_s2);
	assign issue_csrc = q_data.csrc_vld && !half_q;
	assign q_pop = ld_s1 && !(issue_csrc && q_data.summ_vld);

	always_comb begin
		diff = {1'b0, q_data.len} - {1'b0, q_data.pstart};
		stg_n.res.marker = q_data.marker;
		stg_n.res.ptype = q_data.ptype;
		stg_n.res.seq = q_data.seq;
		stg_n.res.timestamp = q_data.timestamp;
		stg_n.res.status = rtph_pkg::ST_OK;
		stg_n.res.ext_present = 1'b0;
		stg_n.res.ext_profile = '0;
		stg_n.res.ext_words = '0;
		stg_n.res.payload_start = '0;
		stg_n.res.pay_len = '0;
		stg_n.pad_chk = 1'b0;
		stg_n.pad_cnt = q_data.pad_cnt;
		stg_n.plen = '0;
		if (issue_csrc) begin
			stg_n.res.kind = rtph_pkg::KIND_CSRC;
			stg_n.res.id_word = q_data.csrc_word;
		end else begin
			stg_n.res.kind = rtph_pkg::KIND_SUMMARY;
			stg_n.res.id_word = q_data.ssrc;
			stg_n.res.ext_present = q_data.ext_present;
			stg_n.res.ext_profile = q_data.ext_profile;
			stg_n.res.ext_words = q_data.ext_words;
			stg_n.res.status = q_data.status;
			if (q_data.status == rtph_pkg::ST_OK) begin
				if (q_data.ext_present && diff[SW]) begin
					stg_n.res.status = rtph_pkg::ST_EXT_DATA_CUT;
				end else begin
					if (q_data.pstart > SW'(rtph_pkg::FIELD_MAX)) begin
						stg_n.res.payload_start = rtph_pkg::FIELD_MAX;
					end else begin
						stg_n.res.payload_start = q_data.pstart[FW-1:0];
					end
					stg_n.plen = diff[SW-1:0];
					stg_n.pad_chk = q_data.pad;
				end
			end
		end
	end

	always_comb begin
		res_n = stg_s1.res;
		plen_f = stg_s1.plen;
		if (stg_s1.pad_chk) begin
			if (stg_s1.plen == '0) begin
				res_n.status = rtph_pkg::ST_PAD_NO_PAYLD;
			end else if (stg_s1.pad_cnt == 8'd0) begin
				res_n.status = rtph_pkg::ST_PAD_ZERO;
			end else if (SW'(stg_s1.pad_cnt) > stg_s1.plen) begin
				res_n.status = rtph_pkg::ST_PAD_TOO_LARGE;
			end else begin
				plen_f = stg_s1.plen - SW'(stg_s1.pad_cnt);
			end
		end
		res_n.pay_len = plen_f[FW-1:0];
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			stg_s1 <= stg_n;
		end
		if (mv_s2) begin
			res_s2 <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			half_q <= 1'b0;
		end else begin
			if (ld_s1) begin
				vld_s1 <= 1'b1;
				half_q <= issue_csrc && q_data.summ_vld;
			end else if (mv_s2) begin
				vld_s1 <= 1'b0;
			end
			if (mv_s2) begin
				vld_s2 <= 1'b1;
			end else if (result_ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	assign result_valid = vld_s2;
	assign result_data = res_s2;

endmodule

FILE: rtl/rtph_header_parser.sv
// RTP header parser for decrypted packets, one byte per cycle. The front end takes a byte
// every cycle that its four-entry queue has room and tracks the byte position and the fixed
// header; each completed CSRC word (up to MAX_CSRC) and the end-of-packet summary go into the
// queue. The back end drains one result per cycle while result_ready is high, through a
// length/padding stage and an output register. A final byte that also completes a CSRC word
// yields two results, CSRC word first, then summary; input runs at one byte per cycle while
// the queue has room. Discard CSRC results of a packet whose summary status is not ok.
module rtp_header_parser #(
	parameter int MAX_CSRC = 4,
	parameter int MAX_PACKET_BYTES = 2048
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           byte_valid,
	output logic           byte_ready,
	input  rtph_pkg::in_t  byte_data,
	output logic           result_valid,
	input  logic           result_ready,
	output rtph_pkg::out_t result_data
);

	localparam int QDEPTH = 4;

	logic            push_valid, q_full, q_valid, q_pop;
	rtph_pkg::qent_t push_data, q_data;

	rtph_front #(
		.MAX_CSRC(MAX_CSRC),
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_data(byte_data),
		.push_valid(push_valid),
		.push_data(push_data),
		.q_full(q_full)
	);

	rtph_queue #(
		.DEPTH(QDEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_data(push_data),
		.full(q_full),
		.pop_valid(q_valid),
		.pop_data(q_data),
		.pop(q_pop)
	);

	rtph_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_data(q_data),
		.q_pop(q_pop),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_data(result_data)
	);

endmodule

FILE: tb/rtp_result_checker.sv
`timescale 1ns / 100ps

module rtp_result_checker #(
	parameter int MAX_CSRC = 4,
	parameter int MAX_PACKET_BYTES = 2048
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_valid,
	input  logic            byte_ready,
	input  rtph_pkg::in_t   byte_data,
	input  logic            result_valid,
	input  logic            result_ready,
	input  rtph_pkg::out_t  result_data,
	output int              errors,
	output int              pending
);

	int              pos;
	logic [7:0]      hdr0, hdr1;
	logic [15:0]     seq_acc;
	logic [31:0]     ts_acc, ssrc_acc, csrc_acc;
	int              csrc_seen;
	logic [15:0]     xprof_acc, xlen_acc;
	logic            xhdr_done;
	rtph_pkg::out_t  expected_results[$];

	function automatic void clear_header();
		hdr0 = '0;
		hdr1 = '0;
		seq_acc = '0;
		ts_acc = '0;
		ssrc_acc = '0;
		csrc_acc = '0;
		csrc_seen = 0;
		xprof_acc = '0;
		xlen_acc = '0;
		xhdr_done = 1'b0;
	endfunction

	function automatic rtph_pkg::out_t header_result(input logic kind,
			input logic [31:0] id);
		rtph_pkg::out_t r;
		r = '0;
		r.kind = kind;
		r.status = rtph_pkg::ST_OK;
		r.marker = hdr1[7];
		r.ptype = hdr1[6:0];
		r.seq = seq_acc;
		r.timestamp = ts_acc;
		r.id_word = id;
		return r;
	endfunction

	function automatic void parse_byte(input logic [7:0] b, input logic last);
		int cc, csrc_end, off, len, pstart, plen;
		logic xbit;
		rtph_pkg::out_t r;
		if (!last && pos >= MAX_PACKET_BYTES - 1)
			return;
		if (pos == 0)
			clear_header();
		cc = hdr0[3:0];
		csrc_end = 12 + 4 * cc;
		xbit = hdr0[4];
		if (pos == 0)
			hdr0 = b;
		else if (pos == 1)
			hdr1 = b;
		else if (pos < 4)
			seq_acc = {seq_acc[7:0], b};
		else if (pos < 8)
			ts_acc = {ts_acc[23:0], b};
		else if (pos < 12)
			ssrc_acc = {ssrc_acc[23:0], b};
		else if (pos < csrc_end) begin
			csrc_acc = {csrc_acc[23:0], b};
			if (((pos - 12) & 3) == 3) begin
				if (csrc_seen < MAX_CSRC)
					expected_results.push_back(
						header_result(rtph_pkg::KIND_CSRC, csrc_acc));
				if (csrc_seen < 15)
					csrc_seen++;
			end
		end else if (xbit && pos < csrc_end + 4) begin
			off = pos - csrc_end;
			if (off < 2)
				xprof_acc = {xprof_acc[7:0], b};
			else
				xlen_acc = {xlen_acc[7:0], b};
			if (off == 3)
				xhdr_done = 1'b1;
		end
		if (!last) begin
			pos++;
			return;
		end

		len = pos + 1;
		cc = hdr0[3:0];
		csrc_end = 12 + 4 * cc;
		xbit = hdr0[4];
		pstart = 0;
		plen = 0;
		r = header_result(rtph_pkg::KIND_SUMMARY, ssrc_acc);
		if (len < 12)
			r.status = rtph_pkg::ST_SHORT;
		else if (hdr0[7:6] != 2'd2)
			r.status = rtph_pkg::ST_VERSION;
		else if (len < csrc_end)
			r.status = rtph_pkg::ST_CSRC_CUT;
		else if (xbit && !xhdr_done)
			r.status = rtph_pkg::ST_EXT_HDR_CUT;
		else if (xbit && len - (csrc_end + 4) < 4 * int'(xlen_acc))
			r.status = rtph_pkg::ST_EXT_DATA_CUT;
		else begin
			pstart = csrc_end + (xbit ? 4 + 4 * int'(xlen_acc) : 0);
			plen = len - pstart;
			if (hdr0[5]) begin
				if (plen == 0)
					r.status = rtph_pkg::ST_PAD_NO_PAYLD;
				else if (b == 0)
					r.status = rtph_pkg::ST_PAD_ZERO;
				else if (int'(b) > plen)
					r.status = rtph_pkg::ST_PAD_TOO_LARGE;
				else
					plen -= b;
			end
		end
		r.ext_present = xbit;
		r.ext_profile = xprof_acc;
		r.ext_words = xlen_acc;
		r.payload_start = (pstart > 2047) ? rtph_pkg::FIELD_MAX :
			pstart[rtph_pkg::FIELD_W-1:0];
		r.pay_len = plen[rtph_pkg::FIELD_W-1:0];
		expected_results.push_back(r);
		pos = 0;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rtph_pkg::out_t want;
		if (!arst_n) begin
			pos = 0;
			clear_header();
			expected_results.delete();
			errors = 0;
		end else begin
			if (byte_valid && byte_ready)
				parse_byte(byte_data.data_byte, byte_data.end_of_packet);
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected transaction, expected none got %0h",
						$time, result_data);
				end else begin
					want = expected_results.pop_front();
					check_field("kind", want.kind, result_data.kind);
					check_field("status", want.status, result_data.status);
					check_field("marker", want.marker, result_data.marker);
					check_field("ptype", want.ptype, result_data.ptype);
					check_field("seq", want.seq, result_data.seq);
					check_field("timestamp", want.timestamp, result_data.timestamp);
					check_field("id_word", want.id_word, result_data.id_word);
					check_field("ext_present", want.ext_present, result_data.ext_present);
					check_field("ext_profile", want.ext_profile, result_data.ext_profile);
					check_field("ext_words", want.ext_words, result_data.ext_words);
					check_field("payload_start", want.payload_start,
						result_data.payload_start);
					check_field("pay_len", want.pay_len, result_data.pay_len);
				end
			end
		end
		pending = expected_results.size();
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int MAX_CSRC = 4;
	localparam int MAX_PACKET_BYTES = 2048;

	logic           clk;
	logic           arst_n;
	logic           byte_valid;
	logic           byte_ready;
	rtph_pkg::in_t  byte_data;
	logic           result_valid;
	logic           result_ready;
	rtph_pkg::out_t result_data;
	int             errors;
	int             pending;
	logic [7:0]     pkt[$];
	bit             quiet;
	bit             long_hold;
	int             bytes_sent;
	int             packets_sent;

	rtp_header_parser #(
		.MAX_CSRC(MAX_CSRC),
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_data(byte_data),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_data(result_data)
	);

	rtp_result_checker #(
		.MAX_CSRC(MAX_CSRC),
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) result_check (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_data(byte_data),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_data(result_data),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(13, 40);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		rtph_pkg::in_t item;
		gap = pick_gap();
		item.data_byte = b;
		item.end_of_packet = last;
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= item;
		do @(posedge clk); while (!byte_ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_packet(input int n);
		for (int i = 0; i < n; i++)
			send_byte(pkt[i], i == n - 1);
		packets_sent++;
	endtask

	task automatic add_random(input int n);
		repeat (n) pkt.push_back(8'($urandom));
	endtask

	task automatic make_header(input logic [1:0] ver, input logic pbit, input logic xbit,
			input logic [3:0] cc, input logic [15:0] xlen, input int xdata);
		pkt.delete();
		pkt.push_back({ver, pbit, xbit, cc});
		add_random(11 + 4 * cc);
		if (xbit) begin
			add_random(2);
			pkt.push_back(xlen[15:8]);
			pkt.push_back(xlen[7:0]);
			add_random(4 * xdata);
		end
	endtask

	task automatic random_packet();
		int r, cc, xdata, payload, fill, cut;
		logic [15:0] xlen;
		logic pbit, xbit;
		r = $urandom_range(0, 99);
		quiet = ($urandom_range(0, 4) == 0);
		if (r >= 90) begin
			pkt.delete();
			add_random($urandom_range(1, 20));
			send_packet(pkt.size());
			return;
		end
		cc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, MAX_CSRC);
		xbit = 1'($urandom);
		pbit = 1'($urandom);
		xdata = $urandom_range(0, 3);
		xlen = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(xdata);
		make_header((r < 80) ? 2'd2 : 2'($urandom), pbit, xbit, 4'(cc), xlen, xdata);
		payload = $urandom_range(0, 12);
		add_random(payload);
		if (pbit) begin
			fill = $urandom_range(0, 3);
			add_random(fill);
			case ($urandom_range(0, 9))
				0: pkt.push_back(8'd0);
				1: pkt.push_back(8'($urandom_range(payload + fill + 2, 255)));
				2: ;
				default: pkt.push_back(8'(fill + 1));
			endcase
		end
		cut = (r >= 65 && r < 80) ? $urandom_range(1, pkt.size()) : pkt.size();
		send_packet(cut);
	endtask

	initial begin
		int hold;
		result_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				result_ready <= 1'b0;
				hold = 300;
			end else begin
				hold = pick_gap();
				result_ready <= (hold == 0);
				if (hold == 0)
					hold = $urandom_range(1, 8);
			end
			repeat (hold) @(negedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_data = '0;
		quiet = 1'b0;
		long_hold = 1'b0;
		bytes_sent = 0;
		packets_sent = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		pkt = '{8'hFF};
		send_packet(1);
		pkt = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
		send_packet(5);
		pkt.delete();
		repeat (12) pkt.push_back(8'hFF);
		send_packet(12);
		make_header(2'd2, 1'b1, 1'b0, 4'd0, 16'd0, 0);
		send_packet(pkt.size());
		make_header(2'd2, 1'b0, 1'b1, 4'd0, 16'hFFFF, 0);
		add_random(3);
		send_packet(pkt.size());

		// drop bytes past the size limit, clamp the payload offset
		make_header(2'd2, 1'b0, 1'b1, 4'd0, 16'd508, 508);
		add_random(40);
		send_packet(pkt.size());
		make_header(2'd2, 1'b1, 1'b0, 4'd15, 16'd0, 0);
		add_random(300);
		pkt.push_back(8'hFF);
		send_packet(pkt.size());

		bytes_sent = 0;
		packets_sent = 0;
		long_hold = 1'b1;
		while (bytes_sent < 800 || packets_sent < 40)
			random_packet();
		byte_valid <= 1'b0;

		wait (pending == 0);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
